// ===== design/obstacle_avoid_heading_steer_macros.svh =====
// Assertion macros for the obstacle avoidance steering block.
`ifndef OBSTACLE_AVOID_HEADING_STEER_MACROS_SVH
`define OBSTACLE_AVOID_HEADING_STEER_MACROS_SVH
`ifndef SYNTHESIS
`define OAHS_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("check failed in %m");
`define OAHS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed in %m");
`else
`define OAHS_ASSERT(label, expr)
`define OAHS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/oahs_pkg.sv =====
`default_nettype none
package oahs_pkg;

   localparam int unsigned PULSE_W     = 16;
   localparam int unsigned RANGE_W     = 16;
   localparam int unsigned HEADING_W   = 12;
   localparam int unsigned GAIN_W      = 7;
   localparam int unsigned HOLD_W      = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned ERR_W       = 14;
   localparam int unsigned MAG_W       = 21;
   localparam int unsigned SUM_W       = MAG_W + 1;
   localparam int unsigned RECIP_W     = 20;
   localparam int unsigned RECIP_SHIFT = 23;

   localparam logic [RECIP_W-1:0]      RECIP_TEN     = 20'd838861;
   localparam logic [RANGE_W-1:0]      OBSTACLE_CM   = 16'd50;
   localparam logic [PULSE_W-1:0]      PART_THROTTLE = 16'd3200;
   localparam logic signed [ERR_W-1:0] HALF_TURN     = 14'sd1800;
   localparam logic signed [ERR_W-1:0] FULL_TURN     = 14'sd3600;

   localparam logic [HOLD_W-1:0] HOLD_UNTIL_NEXT = 8'd0;
   localparam logic [HOLD_W-1:0] HOLD_TURN       = 8'd65;
   localparam logic [HOLD_W-1:0] HOLD_REVERSE    = 8'd150;
   localparam logic [HOLD_W-1:0] HOLD_FORWARD    = 8'd50;

   localparam logic [HEADING_W-1:0] RESET_TARGET_HEADING = 12'd1800;
   localparam logic [GAIN_W-1:0]    RESET_GAIN_TENTHS    = 7'd10;
   localparam logic [PULSE_W-1:0]   RESET_STEER_CENTER   = 16'd2805;
   localparam logic [PULSE_W-1:0]   RESET_STEER_LEFT     = 16'd2185;
   localparam logic [PULSE_W-1:0]   RESET_STEER_RIGHT    = 16'd3275;
   localparam logic [PULSE_W-1:0]   RESET_DRIVE_STOP     = 16'd2765;
   localparam logic [PULSE_W-1:0]   RESET_DRIVE_REVERSE  = 16'd2028;
   localparam logic [PULSE_W-1:0]   RESET_DRIVE_FORWARD  = 16'd3400;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_HEADING,
      CSR_GAIN_TENTHS,
      CSR_STEER_CENTER,
      CSR_STEER_LEFT_LIMIT,
      CSR_STEER_RIGHT_LIMIT,
      CSR_DRIVE_STOP,
      CSR_DRIVE_REVERSE,
      CSR_DRIVE_FORWARD
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_CLEAR,
      PHASE_BACK_UP,
      PHASE_STOP
   } phase_type;

   typedef enum logic [1:0] {
      ACT_STEER,
      ACT_TURN,
      ACT_BACK_UP,
      ACT_STOP
   } action_type;

   typedef struct packed {
      logic [RANGE_W-1:0]   range_cm;
      logic [HEADING_W-1:0] compass_heading;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] steer_pulse;
      logic [PULSE_W-1:0] drive_pulse;
      logic [HOLD_W-1:0]  hold_ticks;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [HEADING_W-1:0] target_heading;
      logic [GAIN_W-1:0]    gain_tenths;
      logic [PULSE_W-1:0]   steer_center;
      logic [PULSE_W-1:0]   steer_left_limit;
      logic [PULSE_W-1:0]   steer_right_limit;
      logic [PULSE_W-1:0]   drive_stop;
      logic [PULSE_W-1:0]   drive_reverse;
      logic [PULSE_W-1:0]   drive_forward;
   } cfg_type;

   typedef struct packed {
      action_type              action;
      logic signed [SUM_W-1:0] sum;
   } work_type;

endpackage
`default_nettype wire

// ===== design/obstacle_avoid_heading_steer.sv =====
// Each request carries a range sample and a compass heading and produces one command, or
// two while backing away from an obstacle, each a steering and drive pulse width with a
// hold time. Requests pass through an input register, a register holding the avoidance
// decision and the scaled heading error, and the output register. A request is taken
// every cycle as long as commands are taken; a request in the back-up phase holds the
// output register for both of its commands, so the next request waits behind it.
// Configuration writes take effect on the next cycle and should be made only while no
// request is in flight.
`default_nettype none
`include "obstacle_avoid_heading_steer_macros.svh"
module obstacle_avoid_heading_steer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  oahs_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output oahs_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [oahs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [oahs_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   oahs_pkg::cfg_type  cfg;
   logic               work_valid;
   logic               work_ready;
   oahs_pkg::work_type work;
   logic               rsp_reverse_fire;
   logic               rsp_is_forward;
   logic               rsp_is_reverse;

   oahs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   oahs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .work_valid  (work_valid),
      .work_ready  (work_ready),
      .work        (work)
   );

   oahs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .work_valid  (work_valid),
      .work_ready  (work_ready),
      .work        (work),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assign rsp_reverse_fire = rsp_valid && rsp_ready && !rsp_payload.last_of_run;
   assign rsp_is_forward   = rsp_payload.last_of_run
                             && rsp_payload.hold_ticks == oahs_pkg::HOLD_FORWARD;
   assign rsp_is_reverse   = rsp_payload.hold_ticks == oahs_pkg::HOLD_REVERSE
                             && rsp_payload.steer_pulse == cfg.steer_right_limit;

   // The reverse command is always followed at once by the forward hard-left command.
   `OAHS_ASSERT_NEXT(a_forward_follows_reverse, rsp_reverse_fire, rsp_valid && rsp_is_forward)
   // Only the reverse command is not the last of its request, and it steers hard right.
   `OAHS_ASSERT(a_only_reverse_not_last, !rsp_valid || rsp_payload.last_of_run || rsp_is_reverse)

endmodule
`default_nettype wire

// ===== design/oahs_csr.sv =====
`default_nettype none
module oahs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [oahs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [oahs_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output oahs_pkg::cfg_type                   cfg
);

   oahs_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (oahs_pkg::csr_index_type'(csr_index))
            oahs_pkg::CSR_TARGET_HEADING: begin
               cfg_in.target_heading = csr_write_data[oahs_pkg::HEADING_W-1:0];
            end
            oahs_pkg::CSR_GAIN_TENTHS: begin
               cfg_in.gain_tenths = csr_write_data[oahs_pkg::GAIN_W-1:0];
            end
            oahs_pkg::CSR_STEER_CENTER: begin
               cfg_in.steer_center = csr_write_data[oahs_pkg::PULSE_W-1:0];
            end
            oahs_pkg::CSR_STEER_LEFT_LIMIT: begin
               cfg_in.steer_left_limit = csr_write_data[oahs_pkg::PULSE_W-1:0];
            end
            oahs_pkg::CSR_STEER_RIGHT_LIMIT: begin
               cfg_in.steer_right_limit = csr_write_data[oahs_pkg::PULSE_W-1:0];
            end
            oahs_pkg::CSR_DRIVE_STOP: begin
               cfg_in.drive_stop = csr_write_data[oahs_pkg::PULSE_W-1:0];
            end
            oahs_pkg::CSR_DRIVE_REVERSE: begin
               cfg_in.drive_reverse = csr_write_data[oahs_pkg::PULSE_W-1:0];
            end
            oahs_pkg::CSR_DRIVE_FORWARD: begin
               cfg_in.drive_forward = csr_write_data[oahs_pkg::PULSE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_heading    <= oahs_pkg::RESET_TARGET_HEADING;
         cfg_ff.gain_tenths       <= oahs_pkg::RESET_GAIN_TENTHS;
         cfg_ff.steer_center      <= oahs_pkg::RESET_STEER_CENTER;
         cfg_ff.steer_left_limit  <= oahs_pkg::RESET_STEER_LEFT;
         cfg_ff.steer_right_limit <= oahs_pkg::RESET_STEER_RIGHT;
         cfg_ff.drive_stop        <= oahs_pkg::RESET_DRIVE_STOP;
         cfg_ff.drive_reverse     <= oahs_pkg::RESET_DRIVE_REVERSE;
         cfg_ff.drive_forward     <= oahs_pkg::RESET_DRIVE_FORWARD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== design/oahs_front.sv =====
`default_nettype none
module oahs_front (
   input  logic                clock,
   input  logic                reset,
   input  oahs_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  oahs_pkg::req_type   req_payload,
   output logic                work_valid,
   input  logic                work_ready,
   output oahs_pkg::work_type  work
);

   localparam int unsigned SUM_W = oahs_pkg::SUM_W;
   localparam int unsigned ERR_W = oahs_pkg::ERR_W;

   logic                    in_valid_ff, in_valid_in;
   oahs_pkg::req_type       in_ff;
   logic                    work_valid_ff, work_valid_in;
   oahs_pkg::work_type      work_ff, work_in;
   oahs_pkg::phase_type     phase_ff, phase_in;
   logic                    advance;
   logic                    req_fire;
   logic signed [ERR_W-1:0] err_raw, err_high, err_wrap;
   logic signed [SUM_W-1:0] err_ext, gain_ext, center_ext, product;

   assign advance   = in_valid_ff && (!work_valid_ff || work_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // Heading error, wrapped once into the half turn either side of the target.
   assign err_raw  = $signed({2'b00, cfg.target_heading})
                   - $signed({2'b00, in_ff.compass_heading});
   assign err_high = (err_raw > oahs_pkg::HALF_TURN) ? err_raw - oahs_pkg::FULL_TURN : err_raw;
   assign err_wrap = (err_high < -oahs_pkg::HALF_TURN) ? err_high + oahs_pkg::FULL_TURN
                                                       : err_high;

   assign err_ext    = {{(SUM_W-ERR_W){err_wrap[ERR_W-1]}}, err_wrap};
   assign gain_ext   = {{(SUM_W-oahs_pkg::GAIN_W){1'b0}}, cfg.gain_tenths};
   assign center_ext = {{(SUM_W-oahs_pkg::PULSE_W){1'b0}}, cfg.steer_center};
   assign product    = err_ext * gain_ext;

   always_comb begin
      phase_in       = phase_ff;
      work_in.sum    = (center_ext <<< 3) + (center_ext <<< 1) + product;
      work_in.action = oahs_pkg::ACT_STEER;
      if (in_ff.range_cm >= oahs_pkg::OBSTACLE_CM) begin
         phase_in = oahs_pkg::PHASE_CLEAR;
      end else begin
         unique case (phase_ff)
            oahs_pkg::PHASE_CLEAR: begin
               work_in.action = oahs_pkg::ACT_TURN;
               phase_in       = oahs_pkg::PHASE_BACK_UP;
            end
            oahs_pkg::PHASE_BACK_UP: begin
               work_in.action = oahs_pkg::ACT_BACK_UP;
               phase_in       = oahs_pkg::PHASE_STOP;
            end
            default: begin
               work_in.action = oahs_pkg::ACT_STOP;
            end
         endcase
      end
   end

   assign in_valid_in   = req_fire || (in_valid_ff && !advance);
   assign work_valid_in = advance || (work_valid_ff && !work_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         work_valid_ff <= 1'b0;
         phase_ff      <= oahs_pkg::PHASE_CLEAR;
      end else begin
         in_valid_ff   <= in_valid_in;
         work_valid_ff <= work_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign work_valid = work_valid_ff;
   assign work       = work_ff;

endmodule
`default_nettype wire

// ===== design/oahs_back.sv =====
`default_nettype none
module oahs_back (
   input  logic                clock,
   input  logic                reset,
   input  oahs_pkg::cfg_type   cfg,
   input  logic                work_valid,
   output logic                work_ready,
   input  oahs_pkg::work_type  work,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output oahs_pkg::rsp_type   rsp_payload
);

   localparam int unsigned SUM_W   = oahs_pkg::SUM_W;
   localparam int unsigned MAG_W   = oahs_pkg::MAG_W;
   localparam int unsigned RECIP_W = oahs_pkg::RECIP_W;
   localparam int unsigned PULSE_W = oahs_pkg::PULSE_W;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        second_ff, second_in;
   oahs_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        load, rsp_fire;
   logic                        negative;
   logic [MAG_W-1:0]            magnitude, quotient;
   logic [MAG_W+RECIP_W-1:0]    scaled;
   logic signed [SUM_W-1:0]     steer_raw, steer_low, steer_sat, left_ext, right_ext;
   logic [PULSE_W-1:0]          steer_law;

   // Division by ten, truncated toward zero, by a reciprocal multiply on the magnitude.
   assign negative  = work.sum[SUM_W-1];
   assign magnitude = negative ? MAG_W'(-work.sum) : MAG_W'(work.sum);
   assign scaled    = {{RECIP_W{1'b0}}, magnitude} * {{MAG_W{1'b0}}, oahs_pkg::RECIP_TEN};
   assign quotient  = {{(oahs_pkg::RECIP_SHIFT-RECIP_W){1'b0}},
                       scaled[MAG_W+RECIP_W-1:oahs_pkg::RECIP_SHIFT]};
   assign steer_raw = negative ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

   assign left_ext  = $signed({{(SUM_W-PULSE_W){1'b0}}, cfg.steer_left_limit});
   assign right_ext = $signed({{(SUM_W-PULSE_W){1'b0}}, cfg.steer_right_limit});
   assign steer_low = (steer_raw < left_ext) ? left_ext : steer_raw;
   assign steer_sat = (steer_low > right_ext) ? right_ext : steer_low;
   assign steer_law = steer_sat[PULSE_W-1:0];

   assign rsp_fire   = rsp_valid_ff && rsp_ready;
   assign work_ready = !rsp_valid_ff || (rsp_ready && !second_ff);
   assign load       = work_valid && work_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      second_in    = second_ff;
      rsp_in       = rsp_ff;
      if (rsp_fire) begin
         if (second_ff) begin
            rsp_in    = '{cfg.steer_left_limit, cfg.drive_forward,
                          oahs_pkg::HOLD_FORWARD, 1'b1};
            second_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         second_in    = 1'b0;
         unique case (work.action)
            oahs_pkg::ACT_STEER: begin
               rsp_in = '{steer_law, cfg.drive_forward, oahs_pkg::HOLD_UNTIL_NEXT, 1'b1};
            end
            oahs_pkg::ACT_TURN: begin
               rsp_in = '{cfg.steer_right_limit, oahs_pkg::PART_THROTTLE,
                          oahs_pkg::HOLD_TURN, 1'b1};
            end
            oahs_pkg::ACT_BACK_UP: begin
               rsp_in    = '{cfg.steer_right_limit, cfg.drive_reverse,
                             oahs_pkg::HOLD_REVERSE, 1'b0};
               second_in = 1'b1;
            end
            oahs_pkg::ACT_STOP: begin
               rsp_in = '{cfg.steer_left_limit, cfg.drive_stop,
                          oahs_pkg::HOLD_UNTIL_NEXT, 1'b1};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
